### src/fapab_pkg.sv
`timescale 1ns / 1ps

package fapab_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd5;

  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_BOUNDS = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] width_in;
    logic signed [31:0] height_in;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] width_out;
    logic signed [31:0] height_out;
  } out_t;

  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] yx;
    logic signed [31:0] yy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } coef_t;

endpackage

### src/fapab_cfg.sv
`timescale 1ns / 1ps

module fapab_cfg #(
  parameter int FRACTION_BITS = fapab_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fapab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  output fapab_pkg::coef_t                 coef
);
  import fapab_pkg::*;

  localparam logic signed [31:0] ONE = 32'(64'sd1 <<< FRACTION_BITS);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.xx <= ONE;
      coef.xy <= '0;
      coef.yx <= '0;
      coef.yy <= ONE;
      coef.tx <= '0;
      coef.ty <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COEF_XX: coef.xx <= $signed(cfg_data);
        CFG_COEF_XY: coef.xy <= $signed(cfg_data);
        CFG_COEF_YX: coef.yx <= $signed(cfg_data);
        CFG_COEF_YY: coef.yy <= $signed(cfg_data);
        CFG_SHIFT_X: coef.tx <= $signed(cfg_data);
        CFG_SHIFT_Y: coef.ty <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

endmodule

### src/fixed_affine_point_and_bounds_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       in         in_valid / in_ready   in_data   (fapab_pkg::in_t)
// out      out        out_valid / out_ready out_data  (fapab_pkg::out_t)
// cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Six register stages: corner scaling, eight 32x32 products, exact sums,
// truncating divide by one, min/max over corners, floor/ceil into the result
// register. One transaction is taken every cycle while no stall backs up to the input.
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles collapse and a stall only halts full stages.
// Reset clears the valid bits and restores the identity matrix.
module fixed_affine_point_and_bounds_top #(
  parameter int FRACTION_BITS = fapab_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fapab_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fapab_pkg::out_t                  out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fapab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);
  import fapab_pkg::*;

  localparam int NSTG  = 6;
  localparam int SUM_W = 66;
  localparam int QW    = SUM_W - FRACTION_BITS;
  localparam logic signed [32:0] FIT_HI = 33'((64'sd1 <<< (31 - FRACTION_BITS)) - 64'sd1);
  localparam logic signed [32:0] FIT_LO = -FIT_HI - 33'sd1;

  coef_t coef;

  fapab_cfg #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  function automatic logic fits_fx(input logic signed [32:0] v);
    fits_fx = (v >= FIT_LO) && (v <= FIT_HI);
  endfunction

  function automatic logic signed [31:0] to_fx(input logic signed [32:0] v);
    to_fx = $signed(v[31:0] << FRACTION_BITS);
  endfunction

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] r;
    r = a * b;
    mul32 = r;
  endfunction

  function automatic logic signed [31:0] min2(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    min2 = (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] max2(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    max2 = (a > b) ? a : b;
  endfunction

  // handshake chain
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 0: scale rectangle corners to fixed point, reject bad rectangles; points pass as is
  logic               s0_op;
  logic               s0_bad;
  logic signed [31:0] s0_cx [2];
  logic signed [31:0] s0_cy [2];

  logic signed [32:0] in_x;
  logic signed [32:0] in_y;
  logic signed [32:0] in_r;
  logic signed [32:0] in_b;

  assign in_x = 33'(in_data.x_in);
  assign in_y = 33'(in_data.y_in);
  assign in_r = 33'(in_data.x_in) + 33'(in_data.width_in);
  assign in_b = 33'(in_data.y_in) + 33'(in_data.height_in);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_op <= in_data.operation;
      if (in_data.operation == OP_POINT) begin
        s0_bad   <= 1'b0;
        s0_cx[0] <= in_data.x_in;
        s0_cx[1] <= in_data.x_in;
        s0_cy[0] <= in_data.y_in;
        s0_cy[1] <= in_data.y_in;
      end else begin
        s0_bad   <= in_data.width_in[31] || in_data.height_in[31] || !fits_fx(in_x) ||
                    !fits_fx(in_y) || !fits_fx(in_r) || !fits_fx(in_b);
        s0_cx[0] <= to_fx(in_x);
        s0_cx[1] <= to_fx(in_r);
        s0_cy[0] <= to_fx(in_y);
        s0_cy[1] <= to_fx(in_b);
      end
    end
  end

  // stage 1: eight products, shared between the corners
  logic               s1_op;
  logic               s1_bad;
  logic signed [63:0] s1_pxa [2];
  logic signed [63:0] s1_pxb [2];
  logic signed [63:0] s1_pya [2];
  logic signed [63:0] s1_pyb [2];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_op  <= s0_op;
      s1_bad <= s0_bad;
      for (int j = 0; j < 2; j++) begin
        s1_pxa[j] <= mul32(coef.xx, s0_cx[j]);
        s1_pxb[j] <= mul32(coef.xy, s0_cy[j]);
        s1_pya[j] <= mul32(coef.yx, s0_cx[j]);
        s1_pyb[j] <= mul32(coef.yy, s0_cy[j]);
      end
    end
  end

  // stage 2: exact sums per corner, indexed [bottom][right]
  logic                     s2_op;
  logic                     s2_bad;
  logic signed [SUM_W-1:0]  s2_sx [2][2];
  logic signed [SUM_W-1:0]  s2_sy [2][2];
  logic signed [SUM_W-1:0]  tx_term;
  logic signed [SUM_W-1:0]  ty_term;

  assign tx_term = SUM_W'(coef.tx) <<< FRACTION_BITS;
  assign ty_term = SUM_W'(coef.ty) <<< FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_op  <= s1_op;
      s2_bad <= s1_bad;
      for (int jy = 0; jy < 2; jy++) begin
        for (int jx = 0; jx < 2; jx++) begin
          s2_sx[jy][jx] <= SUM_W'(s1_pxa[jx]) + SUM_W'(s1_pxb[jy]) + tx_term;
          s2_sy[jy][jx] <= SUM_W'(s1_pya[jx]) + SUM_W'(s1_pyb[jy]) + ty_term;
        end
      end
    end
  end

  // stage 3: divide by one with truncation toward zero, range check
  logic               s3_op;
  logic               s3_bad;
  logic signed [31:0] s3_mx [2][2];
  logic signed [31:0] s3_my [2][2];

  logic signed [QW-1:0] qx [2][2];
  logic signed [QW-1:0] qy [2][2];
  logic                 q_ovf;

  always_comb begin
    q_ovf = 1'b0;
    for (int jy = 0; jy < 2; jy++) begin
      for (int jx = 0; jx < 2; jx++) begin
        qx[jy][jx] = QW'(s2_sx[jy][jx] >>> FRACTION_BITS) +
                     QW'(s2_sx[jy][jx][SUM_W-1] && (s2_sx[jy][jx][FRACTION_BITS-1:0] != '0));
        qy[jy][jx] = QW'(s2_sy[jy][jx] >>> FRACTION_BITS) +
                     QW'(s2_sy[jy][jx][SUM_W-1] && (s2_sy[jy][jx][FRACTION_BITS-1:0] != '0));
        if ((qx[jy][jx][QW-1:31] != '0) && (qx[jy][jx][QW-1:31] != '1)) begin
          q_ovf = 1'b1;
        end
        if ((qy[jy][jx][QW-1:31] != '0) && (qy[jy][jx][QW-1:31] != '1)) begin
          q_ovf = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_op  <= s2_op;
      // a point only uses its first corner; the copies match it anyway
      s3_bad <= s2_bad || q_ovf;
      for (int jy = 0; jy < 2; jy++) begin
        for (int jx = 0; jx < 2; jx++) begin
          s3_mx[jy][jx] <= qx[jy][jx][31:0];
          s3_my[jy][jx] <= qy[jy][jx][31:0];
        end
      end
    end
  end

  // stage 4: min and max over the four corners; a point keeps its first corner as left/top
  logic               s4_op;
  logic               s4_bad;
  logic signed [31:0] s4_left;
  logic signed [31:0] s4_right;
  logic signed [31:0] s4_top;
  logic signed [31:0] s4_bottom;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_op  <= s3_op;
      s4_bad <= s3_bad;
      if (s3_op == OP_POINT) begin
        s4_left <= s3_mx[0][0];
        s4_top  <= s3_my[0][0];
      end else begin
        s4_left <= min2(min2(s3_mx[0][0], s3_mx[0][1]), min2(s3_mx[1][0], s3_mx[1][1]));
        s4_top  <= min2(min2(s3_my[0][0], s3_my[0][1]), min2(s3_my[1][0], s3_my[1][1]));
      end
      s4_right  <= max2(max2(s3_mx[0][0], s3_mx[0][1]), max2(s3_mx[1][0], s3_mx[1][1]));
      s4_bottom <= max2(max2(s3_my[0][0], s3_my[0][1]), max2(s3_my[1][0], s3_my[1][1]));
    end
  end

  // stage 5: floor left/top, ceil right/bottom, sizes into the result register; points pass unrounded
  logic signed [31:0] fl_x;
  logic signed [31:0] fl_y;
  logic signed [32:0] ce_x;
  logic signed [32:0] ce_y;
  logic signed [32:0] sz_w;
  logic signed [32:0] sz_h;
  logic               sz_ok;
  out_t               res;

  always_comb begin
    fl_x  = s4_left >>> FRACTION_BITS;
    fl_y  = s4_top >>> FRACTION_BITS;
    ce_x  = 33'(s4_right >>> FRACTION_BITS) +
            {32'd0, (s4_right[FRACTION_BITS-1:0] != '0)};
    ce_y  = 33'(s4_bottom >>> FRACTION_BITS) +
            {32'd0, (s4_bottom[FRACTION_BITS-1:0] != '0)};
    sz_w  = ce_x - 33'(fl_x);
    sz_h  = ce_y - 33'(fl_y);
    sz_ok = (sz_w[32] == sz_w[31]) && (sz_h[32] == sz_h[31]);
    res   = '0;
    if (s4_op == OP_POINT) begin
      if (!s4_bad) begin
        res.ok    = 1'b1;
        res.x_out = s4_left;
        res.y_out = s4_top;
      end
    end else if (!s4_bad && sz_ok) begin
      res.ok         = 1'b1;
      res.x_out      = fl_x;
      res.y_out      = fl_y;
      res.width_out  = sz_w[31:0];
      res.height_out = sz_h[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  // a draining output never blocks the input side
  assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // a failed result carries no coordinates
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |-> out_data.x_out == '0 && out_data.y_out == '0 &&
      out_data.width_out == '0 && out_data.height_out == '0)
    else $error("failed result with non-zero fields");

  // bounding sizes are never negative
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ok |-> !out_data.width_out[31] && !out_data.height_out[31])
    else $error("negative bounding size");

  // a stalled corner stage keeps its item
  assert property (@(posedge clk) disable iff (rst)
    vld[3] && !rdy[3] |=> vld[3] && $stable(s3_bad) && $stable(s3_op))
    else $error("corner stage lost its transaction under stall");

  // nothing enters the pipe without an accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    !vld[0] && !(in_valid && in_ready) |=> !vld[0])
    else $error("first stage filled without a transaction");
`endif

endmodule
